// ----- hw/rtl/inv3_pkg.sv -----
package inv3_pkg;

	localparam int unsigned FRAC_BITS_DEF = 16;
	localparam int unsigned EW = 32;
	localparam int unsigned CW = 64;
	localparam int unsigned DETW = 99;
	localparam int unsigned DW = DETW + 1;
	localparam int unsigned QBITS = 32;
	localparam int unsigned RW = DW + QBITS + 1;
	localparam int unsigned LANES = 9;

	typedef struct packed {
		logic signed [EW-1:0] m00;
		logic signed [EW-1:0] m01;
		logic signed [EW-1:0] m02;
		logic signed [EW-1:0] m10;
		logic signed [EW-1:0] m11;
		logic signed [EW-1:0] m12;
		logic signed [EW-1:0] m20;
		logic signed [EW-1:0] m21;
		logic signed [EW-1:0] m22;
	} mat_t;

	typedef struct packed {
		logic signed [EW-1:0] r00;
		logic signed [EW-1:0] r01;
		logic signed [EW-1:0] r02;
		logic signed [EW-1:0] r10;
		logic signed [EW-1:0] r11;
		logic signed [EW-1:0] r12;
		logic signed [EW-1:0] r20;
		logic signed [EW-1:0] r21;
		logic signed [EW-1:0] r22;
		logic                 singular;
		logic                 clamped;
	} inv_t;

	typedef struct packed {
		logic [RW-1:0]    r;
		logic [QBITS-1:0] q;
		logic             ovf;
		logic             neg;
	} lane_t;

	typedef struct packed {
		lane_t [LANES-1:0] lane;
		logic [DW-1:0]     d;
		logic              sing;
	} div_t;

endpackage

// ----- hw/rtl/inv3_front.sv -----
module inv3_front import inv3_pkg::*; #(
	parameter int unsigned FRAC_BITS = FRAC_BITS_DEF
) (
	input  logic clk,
	input  logic arst_n,
	input  logic in_valid,
	output logic in_stall,
	input  mat_t in_data,
	output logic out_valid,
	input  logic out_stall,
	output div_t out_data
);

	function automatic logic signed [CW-1:0] mul32(logic signed [EW-1:0] x,
			logic signed [EW-1:0] y);
		mul32 = CW'(x) * CW'(y);
	endfunction

	logic v_s1, v_s2, v_s3, v_s4, v_s5, v_s6;
	logic b1, b2, b3, b4, b5, b6;

	logic signed [EW-1:0] a_s1 [3];
	logic signed [EW-1:0] a_s2 [3];
	logic signed [CW-1:0] pa_s1 [9];
	logic signed [CW-1:0] pb_s1 [9];
	logic signed [CW-1:0] cof_s2 [9];
	logic signed [CW-1:0] cof_s3 [9];
	logic signed [CW-1:0] cof_s4 [9];
	logic signed [CW-1:0] cof_s5 [9];
	logic signed [CW:0]   lo_s3 [3];
	logic signed [CW-1:0] hi_s3 [3];
	logic signed [DETW-1:0] pr_s4 [3];
	logic signed [DETW-1:0] det_s5;
	div_t dv_s6;

	assign b6 = v_s6 & out_stall;
	assign b5 = v_s5 & b6;
	assign b4 = v_s4 & b5;
	assign b3 = v_s3 & b4;
	assign b2 = v_s2 & b3;
	assign b1 = v_s1 & b2;
	assign in_stall = b1;
	assign out_valid = v_s6;
	assign out_data = dv_s6;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
			v_s5 <= 1'b0;
			v_s6 <= 1'b0;
		end else begin
			if (!b1) v_s1 <= in_valid;
			if (!b2) v_s2 <= v_s1;
			if (!b3) v_s3 <= v_s2;
			if (!b4) v_s4 <= v_s3;
			if (!b5) v_s5 <= v_s4;
			if (!b6) v_s6 <= v_s5;
		end
	end

	// products for cofactors
	always_ff @(posedge clk) begin
		if (!b1) begin
			a_s1[0] <= in_data.m00;
			a_s1[1] <= in_data.m01;
			a_s1[2] <= in_data.m02;
			pa_s1[0] <= mul32(in_data.m11, in_data.m22);
			pb_s1[0] <= mul32(in_data.m12, in_data.m21);
			pa_s1[1] <= mul32(in_data.m12, in_data.m20);
			pb_s1[1] <= mul32(in_data.m10, in_data.m22);
			pa_s1[2] <= mul32(in_data.m10, in_data.m21);
			pb_s1[2] <= mul32(in_data.m11, in_data.m20);
			pa_s1[3] <= mul32(in_data.m02, in_data.m21);
			pb_s1[3] <= mul32(in_data.m01, in_data.m22);
			pa_s1[4] <= mul32(in_data.m00, in_data.m22);
			pb_s1[4] <= mul32(in_data.m02, in_data.m20);
			pa_s1[5] <= mul32(in_data.m01, in_data.m20);
			pb_s1[5] <= mul32(in_data.m00, in_data.m21);
			pa_s1[6] <= mul32(in_data.m01, in_data.m12);
			pb_s1[6] <= mul32(in_data.m02, in_data.m11);
			pa_s1[7] <= mul32(in_data.m02, in_data.m10);
			pb_s1[7] <= mul32(in_data.m00, in_data.m12);
			pa_s1[8] <= mul32(in_data.m00, in_data.m11);
			pb_s1[8] <= mul32(in_data.m01, in_data.m10);
		end
	end

	always_ff @(posedge clk) begin
		if (!b2) begin
			a_s2 <= a_s1;
			for (int k = 0; k < 9; k++) cof_s2[k] <= pa_s1[k] - pb_s1[k];
		end
	end

	// row 0 times cofactor, split in 32-bit halves
	always_ff @(posedge clk) begin
		if (!b3) begin
			cof_s3 <= cof_s2;
			for (int k = 0; k < 3; k++) begin
				lo_s3[k] <= (CW+1)'(a_s2[k]) * $signed({33'b0, cof_s2[k][EW-1:0]});
				hi_s3[k] <= CW'(a_s2[k]) * CW'($signed(cof_s2[k][CW-1:EW]));
			end
		end
	end

	always_ff @(posedge clk) begin
		if (!b4) begin
			cof_s4 <= cof_s3;
			for (int k = 0; k < 3; k++)
				pr_s4[k] <= DETW'(lo_s3[k]) + (DETW'(hi_s3[k]) <<< EW);
		end
	end

	always_ff @(posedge clk) begin
		if (!b5) begin
			cof_s5 <= cof_s4;
			det_s5 <= pr_s4[0] + pr_s4[1] + pr_s4[2];
		end
	end

	// numerator and divisor per lane
	always_ff @(posedge clk) begin
		logic              dneg;
		logic [DETW-1:0]   dmag;
		logic signed [CW-1:0] c;
		logic [CW-1:0]     cm;
		logic [RW-1:0]     num;
		if (!b6) begin
			dneg = det_s5[DETW-1];
			dmag = dneg ? DETW'(-det_s5) : DETW'(det_s5);
			dv_s6.d <= {dmag, 1'b0};
			dv_s6.sing <= (det_s5 == '0);
			for (int i = 0; i < 3; i++) begin
				for (int j = 0; j < 3; j++) begin
					c = cof_s5[3*j+i];
					cm = c[CW-1] ? CW'(-c) : CW'(c);
					num = RW'(cm) << (2*FRAC_BITS);
					dv_s6.lane[3*i+j].r <= (num << 1) + RW'(dmag);
					dv_s6.lane[3*i+j].q <= '0;
					dv_s6.lane[3*i+j].ovf <= 1'b0;
					dv_s6.lane[3*i+j].neg <= (c != '0) & (c[CW-1] ^ dneg);
				end
			end
		end
	end

endmodule

// ----- hw/rtl/inv3_div_step.sv -----
module inv3_div_step import inv3_pkg::*; #(
	parameter int unsigned SHIFT = QBITS
) (
	input  logic clk,
	input  logic arst_n,
	input  logic in_valid,
	output logic in_stall,
	input  div_t in_data,
	output logic out_valid,
	input  logic out_stall,
	output div_t out_data
);

	logic v_s1;
	div_t nx;
	div_t dv_s1;
	logic [RW-1:0] dsh;

	assign in_stall = v_s1 & out_stall;
	assign out_valid = v_s1;
	assign out_data = dv_s1;
	assign dsh = RW'(in_data.d) << SHIFT;

	generate
		if (SHIFT >= QBITS) begin : g_ovf
			always_comb begin
				nx = in_data;
				for (int k = 0; k < LANES; k++)
					nx.lane[k].ovf = (in_data.lane[k].r >= dsh);
			end
		end else begin : g_bit
			always_comb begin
				nx = in_data;
				for (int k = 0; k < LANES; k++) begin
					if (in_data.lane[k].r >= dsh) begin
						nx.lane[k].r = in_data.lane[k].r - dsh;
						nx.lane[k].q[SHIFT] = 1'b1;
					end
				end
			end
		end
	endgenerate

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (!in_stall) begin
			v_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (!in_stall) dv_s1 <= nx;
	end

endmodule

// ----- hw/rtl/inverse_3x3_core.sv -----
// 3x3 matrix inverse, signed Q16.16 in and out (FRAC_BITS sets the format).
// Input channel mat_valid / mat_stall / mat carries one matrix per beat,
// row-major. Output channel inv_valid / inv_stall / inv carries the nine
// inverse entries plus singular and clamped flags, one beat per matrix.
// A zero determinant gives all-zero entries with singular set; entries past
// the 32-bit range saturate and set clamped.
// Throughput: one matrix per cycle while inv_stall is low. Pipeline: 6
// cofactor/determinant stages, 33 restoring divider stages and one output
// stage from accept to inv_valid. The divider array is what sets the depth.
// Reset clears every stage valid; no results are pending after reset.
// When the receiver holds inv_stall, the stalled beat and its payload hold;
// upstream stages keep filling empty slots, and mat_stall rises only when
// every stage up to the input is occupied.
module inverse_3x3_core import inv3_pkg::*; #(
	parameter int unsigned FRAC_BITS = FRAC_BITS_DEF
) (
	input  logic clk,
	input  logic arst_n,
	input  logic mat_valid,
	output logic mat_stall,
	input  mat_t mat,
	output logic inv_valid,
	input  logic inv_stall,
	output inv_t inv
);

	localparam int unsigned NSTEP = QBITS + 1;

	logic v_c [NSTEP+1];
	logic s_c [NSTEP+1];
	div_t d_c [NSTEP+1];

	logic out_v_q;
	inv_t out_q;
	logic ob;
	logic [EW-1:0] rv [LANES];
	logic clamp;

	inv3_front #(.FRAC_BITS(FRAC_BITS)) u_front (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(mat_valid),
		.in_stall(mat_stall),
		.in_data(mat),
		.out_valid(v_c[0]),
		.out_stall(s_c[0]),
		.out_data(d_c[0])
	);

	generate
		for (genvar g = 0; g < NSTEP; g++) begin : g_div
			inv3_div_step #(.SHIFT(QBITS - g)) u_step (
				.clk(clk),
				.arst_n(arst_n),
				.in_valid(v_c[g]),
				.in_stall(s_c[g]),
				.in_data(d_c[g]),
				.out_valid(v_c[g+1]),
				.out_stall(s_c[g+1]),
				.out_data(d_c[g+1])
			);
		end
	endgenerate

	assign ob = out_v_q & inv_stall;
	assign s_c[NSTEP] = ob;
	assign inv_valid = out_v_q;
	assign inv = out_q;

	always_comb begin
		lane_t l;
		clamp = 1'b0;
		for (int k = 0; k < LANES; k++) begin
			l = d_c[NSTEP].lane[k];
			if (l.neg) begin
				if (l.ovf || l.q > {1'b1, {(QBITS-1){1'b0}}}) begin
					rv[k] = {1'b1, {(EW-1){1'b0}}};
					clamp = 1'b1;
				end else begin
					rv[k] = EW'(-l.q);
				end
			end else begin
				if (l.ovf || l.q[QBITS-1]) begin
					rv[k] = {1'b0, {(EW-1){1'b1}}};
					clamp = 1'b1;
				end else begin
					rv[k] = EW'(l.q);
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_v_q <= 1'b0;
		end else if (!ob) begin
			out_v_q <= v_c[NSTEP];
		end
	end

	always_ff @(posedge clk) begin
		if (!ob) begin
			if (d_c[NSTEP].sing) begin
				out_q <= {{(LANES*EW){1'b0}}, 1'b1, 1'b0};
			end else begin
				out_q.r00 <= rv[0];
				out_q.r01 <= rv[1];
				out_q.r02 <= rv[2];
				out_q.r10 <= rv[3];
				out_q.r11 <= rv[4];
				out_q.r12 <= rv[5];
				out_q.r20 <= rv[6];
				out_q.r21 <= rv[7];
				out_q.r22 <= rv[8];
				out_q.singular <= 1'b0;
				out_q.clamped <= clamp;
			end
		end
	end

endmodule
